>>> sv/jcr_pkg.sv
// ----------------------------------------------------------------------------
// jcr_pkg
// Shared types and constants of the jitter colour reduction block.
// ----------------------------------------------------------------------------
package jcr_pkg;

    typedef enum logic [1:0] {
        OP_PIXEL      = 2'd0,
        OP_LOAD_ORDER = 2'd1,
        OP_LOAD_X     = 2'd2,
        OP_LOAD_Y     = 2'd3
    } jcr_op_t;

    // Write strobes for the three jitter tables, one per table.
    typedef struct packed {
        logic ord_we;
        logic xj_we;
        logic yn_we;
    } jcr_wr_t;

    localparam int NUM_CHAN      = 3;
    localparam int XJ_W          = 4;
    localparam int YN_W          = 6;
    localparam int NOISE_W       = 2;
    localparam int X_JITTER_MULT = 9;

    localparam logic [NOISE_W-1:0] NOISE_RESET = 2'd2;
    localparam logic [7:0]         PASS_LIMIT  = 8'd248;
    localparam logic [7:0]         CHAN_MASK   = 8'hf8;
    localparam logic [7:0]         BUMP        = 8'd8;

endpackage

>>> sv/jcr_ram.sv
// ----------------------------------------------------------------------------
// jcr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module jcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read and a write to the same entry in one cycle return the old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> sv/jcr_lane.sv
// ----------------------------------------------------------------------------
// jcr_lane
// One colour channel: its own copies of the three tables, the two-level
// table lookup and the jitter arithmetic, over three register stages.
// ----------------------------------------------------------------------------
module jcr_lane import jcr_pkg::*; #(
    parameter int TABLE_BITS = 10,
    parameter int CHAN       = 0
) (
    input  logic                  clk,
    input  logic                  en1,
    input  logic                  en2,
    input  logic                  en3,
    input  jcr_wr_t               wr,
    input  logic [TABLE_BITS-1:0] wr_addr,
    input  logic [TABLE_BITS-1:0] ord_wdata,
    input  logic [XJ_W-1:0]       xj_wdata,
    input  logic [YN_W-1:0]       yn_wdata,
    input  logic [13:0]           pix_x,
    input  logic [13:0]           pix_y,
    input  logic [7:0]            value_in,
    output logic [7:0]            value_out
);

    localparam int DEPTH = 2 ** TABLE_BITS;

    logic [TABLE_BITS-1:0] ord_addr_a;
    logic [TABLE_BITS-1:0] ord_addr_b;
    logic [TABLE_BITS-1:0] ord_a;
    logic [TABLE_BITS-1:0] ord_b;
    logic [TABLE_BITS-1:0] px_reg;
    logic [TABLE_BITS-1:0] py_reg;
    logic [7:0]            v1_reg;
    logic [TABLE_BITS-1:0] xi;
    logic [TABLE_BITS-1:0] yi;
    logic [XJ_W-1:0]       xj;
    logic [YN_W-1:0]       yn;
    logic [7:0]            v2_reg;
    logic [7:0]            bumped;
    logic signed [9:0]     sum;
    logic [7:0]            noisy;
    logic [7:0]            value_next;
    logic [7:0]            value_reg;

    // Stage 1: order table lookups, offset by the channel number.
    assign ord_addr_a = TABLE_BITS'(pix_x) + TABLE_BITS'(CHAN);
    assign ord_addr_b = TABLE_BITS'(pix_y) + TABLE_BITS'(CHAN);

    jcr_ram #(.WIDTH(TABLE_BITS), .DEPTH(DEPTH)) u_ord_a (
        .clk(clk), .we(wr.ord_we), .waddr(wr_addr), .wdata(ord_wdata),
        .re(en1), .raddr(ord_addr_a), .rdata(ord_a)
    );

    jcr_ram #(.WIDTH(TABLE_BITS), .DEPTH(DEPTH)) u_ord_b (
        .clk(clk), .we(wr.ord_we), .waddr(wr_addr), .wdata(ord_wdata),
        .re(en1), .raddr(ord_addr_b), .rdata(ord_b)
    );

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            px_reg <= TABLE_BITS'(pix_x);
            py_reg <= TABLE_BITS'(pix_y);
            v1_reg <= value_in;
        end
    end

    // Stage 2: jitter table lookups at the scrambled coordinates.
    assign xi = px_reg + TABLE_BITS'({py_reg, 2'b00}) + ord_a;
    assign yi = py_reg + TABLE_BITS'({px_reg, 2'b00}) + ord_b;

    jcr_ram #(.WIDTH(XJ_W), .DEPTH(DEPTH)) u_xj (
        .clk(clk), .we(wr.xj_we), .waddr(wr_addr), .wdata(xj_wdata),
        .re(en2), .raddr(xi), .rdata(xj)
    );

    jcr_ram #(.WIDTH(YN_W), .DEPTH(DEPTH)) u_yn (
        .clk(clk), .we(wr.yn_we), .waddr(wr_addr), .wdata(yn_wdata),
        .re(en2), .raddr(yi), .rdata(yn)
    );

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            v2_reg <= v1_reg;
        end
    end

    // Stage 3: bump, add in-range noise, truncate; high values pass.
    always_comb
    begin
        if ({1'b0, v2_reg[2:0]} <= xj)
        begin
            bumped = v2_reg + BUMP;
        end
        else
        begin
            bumped = v2_reg;
        end
        sum = signed'({2'b00, bumped}) + signed'({{4{yn[YN_W-1]}}, yn});
        if (sum[9:8] == 2'b00)
        begin
            noisy = sum[7:0];
        end
        else
        begin
            noisy = bumped;
        end
        if (v2_reg >= PASS_LIMIT)
        begin
            value_next = v2_reg;
        end
        else
        begin
            value_next = noisy & CHAN_MASK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            value_reg <= value_next;
        end
    end

    assign value_out = value_reg;

endmodule

>>> sv/jitter_color_reduce.sv
// ----------------------------------------------------------------------------
// jitter_color_reduce
// Jitters 24-bit pixels ahead of a cut to 5 bits per channel.
// ----------------------------------------------------------------------------
// The block takes one word per clock while in_ready is high, pixels and table
// loads alike, and passes each pixel through three register stages before
// its result word is offered; a stalled output can hold the stages back.
// The three stages are the order table read,
// the jitter table reads and the channel arithmetic; each channel has its
// own copies of the tables so that the channels of a pixel read them side by side.
// Loads write every copy when the word is taken and give no result. Table
// entries must be loaded before a pixel uses them. The noise level register
// only affects Y table loads made after it is written.
module jitter_color_reduce import jcr_pkg::*; #(
    parameter int TABLE_BITS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [NOISE_W-1:0] cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  logic [13:0]        pix_x,
    input  logic [13:0]        pix_y,
    input  logic [7:0]         red_in,
    input  logic [7:0]         green_in,
    input  logic [7:0]         blue_in,
    input  logic [9:0]         table_index,
    input  logic [9:0]         random_word,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         red_out,
    output logic [7:0]         green_out,
    output logic [7:0]         blue_out
);

    localparam logic [TABLE_BITS+2:0] HALF = (TABLE_BITS+3)'(2 ** (TABLE_BITS - 1));

    logic [NOISE_W-1:0]    noise_reg;
    logic                  v1_reg;
    logic                  v2_reg;
    logic                  v3_reg;
    logic                  v1_next;
    logic                  v2_next;
    logic                  v3_next;
    logic                  en1;
    logic                  en2;
    logic                  en3;
    logic                  accept;
    jcr_op_t               op_code;
    jcr_wr_t               wr;
    logic [TABLE_BITS-1:0] wr_addr;
    logic [TABLE_BITS-1:0] word;
    logic [TABLE_BITS+3:0] xj_prod;
    logic [TABLE_BITS+2:0] yn_prod;
    logic [2:0]            yn_step;
    logic signed [3:0]     yn_diff;
    logic [XJ_W-1:0]       xj_wdata;
    logic [YN_W-1:0]       yn_wdata;
    logic [7:0]            chan_in  [NUM_CHAN];
    logic [7:0]            chan_out [NUM_CHAN];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_reg <= NOISE_RESET;
        end
        else if (cfg_we)
        begin
            noise_reg <= cfg_wdata;
        end
    end

    // Each stage moves when the stage after it is empty or moving.
    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;
    assign accept   = in_valid && in_ready;
    assign op_code  = jcr_op_t'(op);

    always_comb
    begin
        v1_next = v1_reg;
        v2_next = v2_reg;
        v3_next = v3_reg;
        if (en1)
        begin
            v1_next = accept && (op_code == OP_PIXEL);
        end
        if (en2)
        begin
            v2_next = v1_reg;
        end
        if (en3)
        begin
            v3_next = v2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // Table entry values, formed from the random word as it is taken.
    assign wr_addr  = TABLE_BITS'(table_index);
    assign word     = TABLE_BITS'(random_word);
    assign xj_prod  = (TABLE_BITS+4)'(word) * (TABLE_BITS+4)'(X_JITTER_MULT);
    assign xj_wdata = XJ_W'(xj_prod >> TABLE_BITS);
    assign yn_prod  = (TABLE_BITS+3)'(word) * (TABLE_BITS+3)'({noise_reg, 1'b0}) + HALF;
    assign yn_step  = 3'(yn_prod >> TABLE_BITS);
    assign yn_diff  = signed'({1'b0, yn_step}) - signed'({2'b00, noise_reg});
    assign yn_wdata = {yn_diff[2:0], 3'b000};

    assign wr.ord_we = accept && (op_code == OP_LOAD_ORDER);
    assign wr.xj_we  = accept && (op_code == OP_LOAD_X);
    assign wr.yn_we  = accept && (op_code == OP_LOAD_Y);

    assign chan_in[0] = red_in;
    assign chan_in[1] = green_in;
    assign chan_in[2] = blue_in;

    for (genvar g = 0; g < NUM_CHAN; g++)
    begin : g_lane
        jcr_lane #(.TABLE_BITS(TABLE_BITS), .CHAN(g)) u_lane (
            .clk      (clk),
            .en1      (en1),
            .en2      (en2),
            .en3      (en3),
            .wr       (wr),
            .wr_addr  (wr_addr),
            .ord_wdata(word),
            .xj_wdata (xj_wdata),
            .yn_wdata (yn_wdata),
            .pix_x    (pix_x),
            .pix_y    (pix_y),
            .value_in (chan_in[g]),
            .value_out(chan_out[g])
        );
    end

    assign out_valid = v3_reg;
    assign red_out   = chan_out[0];
    assign green_out = chan_out[1];
    assign blue_out  = chan_out[2];

endmodule

>>> sv/jcr_checker.sv
// ----------------------------------------------------------------------------
// jcr_checker
// Port-level checks of the jitter colour reduction block.
// ----------------------------------------------------------------------------
module jcr_checker import jcr_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic [7:0]         red_out,
    input logic [7:0]         green_out,
    input logic [7:0]         blue_out
);

    // A result word held back by the sink keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red_out)
            && $stable(green_out) && $stable(blue_out))
        else $error("result word changed while stalled");

    // Every channel is either truncated to 5 bits or a passed-through high value.
    a_trunc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (red_out[2:0] == 3'b000 || red_out >= PASS_LIMIT)
            && (green_out[2:0] == 3'b000 || green_out >= PASS_LIMIT)
            && (blue_out[2:0] == 3'b000 || blue_out >= PASS_LIMIT))
        else $error("result channel not truncated");

    // Nothing is offered while the block is held in reset.
    a_reset: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result offered during reset");

endmodule

bind jitter_color_reduce jcr_checker u_jcr_checker (.*);

>>> tb/jitter_color_reduce_tb.sv
// ----------------------------------------------------------------------------
// jitter_color_reduce_tb
// Self-checking bench for the jitter colour reduction block. Pixel coordinates
// keep their low table bits in a small window around zero and order words are
// small offsets, so every table entry a pixel can reach is known; those
// entries are loaded first, so that no pixel ever reads an unloaded entry.
// Then come a directed set of pixels and loads, and random phases at every
// noise level, with the Y window reloaded after each level change. A
// scoreboard predicts each result word from its own copy of the tables.
// ----------------------------------------------------------------------------
module jitter_color_reduce_tb;
    import jcr_pkg::*;

    localparam int TABLE_BITS  = 10;
    localparam int TABLE_SIZE  = 1 << TABLE_BITS;
    localparam int TMASK       = TABLE_SIZE - 1;
    localparam int CHAN_MAX    = 255;
    localparam int HOLD_CYCLES = 150;
    localparam int REPORT_MAX  = 10;
    localparam int PHASE_WORDS = 110;

    // Low coordinate bits and order words are taken as small signed offsets.
    localparam int COORD_LO  = -4;
    localparam int COORD_HI  = 3;
    localparam int ORDER_LO  = -8;
    localparam int ORDER_HI  = 7;
    localparam int ORD_FIRST = COORD_LO;
    localparam int ORD_LAST  = COORD_HI + NUM_CHAN - 1;
    localparam int JIT_FIRST = COORD_LO * 5 + ORDER_LO;
    localparam int JIT_LAST  = COORD_HI * 5 + ORDER_HI;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    class jitter_scoreboard;
        logic [9:0]         order_tab [TABLE_SIZE];
        logic [XJ_W-1:0]    xjit_tab [TABLE_SIZE];
        int                 ynoise_tab [TABLE_SIZE];
        logic [NOISE_W-1:0] noise_sel;
        rgb_t               expected_q [$];
        int                 errors;

        function new();
            noise_sel = NOISE_RESET;
            errors    = 0;
        endfunction

        function void set_noise(logic [NOISE_W-1:0] lvl);
            noise_sel = lvl;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [7:0] jitter_channel(logic [7:0] v, int px, int py, int c);
            int vi;
            int xi;
            int yi;
            int q;
            if (v >= PASS_LIMIT)
                return v;
            xi = (px + (py << 2) + int'(order_tab[(px + c) & TMASK])) & TMASK;
            yi = (py + (px << 2) + int'(order_tab[(py + c) & TMASK])) & TMASK;
            vi = int'(v);
            if ((vi & 7) <= int'(xjit_tab[xi]))
                vi += int'(BUMP);
            // The noise is dropped when it would carry the channel out of range.
            q = vi + ynoise_tab[yi];
            if (q >= 0 && q <= CHAN_MAX)
                vi = q;
            return vi[7:0] & CHAN_MASK;
        endfunction

        function void note_word(jcr_op_t o, logic [13:0] px, logic [13:0] py,
                                logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                logic [9:0] idx, logic [9:0] w);
            rgb_t exp_pix;
            int   t;
            case (o)
                OP_PIXEL:
                begin
                    exp_pix.red   = jitter_channel(r, int'(px), int'(py), 0);
                    exp_pix.green = jitter_channel(g, int'(px), int'(py), 1);
                    exp_pix.blue  = jitter_channel(b, int'(px), int'(py), 2);
                    expected_q.push_back(exp_pix);
                end
                OP_LOAD_ORDER:
                    order_tab[idx] = w;
                OP_LOAD_X:
                    xjit_tab[idx] = XJ_W'((int'(w) * X_JITTER_MULT) >> TABLE_BITS);
                default:
                begin
                    t = (int'(w) * int'(noise_sel) * 2 + TABLE_SIZE / 2) >> TABLE_BITS;
                    ynoise_tab[idx] = (t - int'(noise_sel)) * 8;
                end
            endcase
        endfunction

        function void check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            rgb_t exp_pix;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected result word %0d %0d %0d", r, g, b);
                return;
            end
            exp_pix = expected_q.pop_front();
            if (exp_pix.red !== r || exp_pix.green !== g || exp_pix.blue !== b)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                             exp_pix.red, exp_pix.green, exp_pix.blue, r, g, b);
            end
        endfunction
    endclass

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_we      = 1'b0;
    logic [NOISE_W-1:0] cfg_wdata   = '0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic [1:0]         op          = '0;
    logic [13:0]        pix_x       = '0;
    logic [13:0]        pix_y       = '0;
    logic [7:0]         red_in      = '0;
    logic [7:0]         green_in    = '0;
    logic [7:0]         blue_in     = '0;
    logic [9:0]         table_index = '0;
    logic [9:0]         random_word = '0;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic [7:0]         red_out;
    logic [7:0]         green_out;
    logic [7:0]         blue_out;

    bit brisk;
    bit hold_due;
    jitter_scoreboard sb;

    jitter_color_reduce #(.TABLE_BITS(TABLE_BITS)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .pix_x       (pix_x),
        .pix_y       (pix_y),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .table_index (table_index),
        .random_word (random_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Both sides only change on nonblocking updates, so the values seen here
    // are those present at the edge.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_word(jcr_op_t'(op), pix_x, pix_y, red_in, green_in, blue_in,
                         table_index, random_word);
        if (rst_n && out_valid && out_ready)
            sb.check_result(red_out, green_out, blue_out);
    end

    function automatic int gap_draw();
        return brisk ? 0 : int'($urandom_range(0, 4));
    endfunction

    // Channel values lean towards both ends, where the pass-through limit and
    // the range check on the noise come into play.
    function automatic logic [7:0] random_channel();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(0, 15));
            1:       return 8'($urandom_range(232, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Upper bits are free; the low table bits stay inside the window.
    function automatic logic [13:0] random_coord();
        return {4'($urandom_range(0, 15)),
                10'(int'($urandom_range(0, COORD_HI - COORD_LO)) + COORD_LO)};
    endfunction

    function automatic logic [9:0] order_word();
        return 10'(int'($urandom_range(0, ORDER_HI - ORDER_LO)) + ORDER_LO);
    endfunction

    function automatic logic [9:0] load_word(jcr_op_t o);
        if (o == OP_LOAD_ORDER)
            return order_word();
        return 10'($urandom_range(0, 1023));
    endfunction

    task automatic send_word(jcr_op_t o, logic [13:0] px, logic [13:0] py,
                             logic [7:0] r, logic [7:0] g, logic [7:0] b,
                             logic [9:0] idx, logic [9:0] w);
        int gap;
        gap = gap_draw();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= o;
        pix_x       <= px;
        pix_y       <= py;
        red_in      <= r;
        green_in    <= g;
        blue_in     <= b;
        table_index <= idx;
        random_word <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_pixel(logic [13:0] px, logic [13:0] py,
                              logic [7:0] r, logic [7:0] g, logic [7:0] b);
        send_word(OP_PIXEL, px, py, r, g, b,
                  10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
    endtask

    task automatic send_load(jcr_op_t o, logic [9:0] idx, logic [9:0] w);
        send_word(o, 14'($urandom_range(0, 16383)), 14'($urandom_range(0, 16383)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), idx, w);
    endtask

    // Loads a run of entries of one table, wrapping below zero; the end
    // entries get the extreme words.
    task automatic fill_table(jcr_op_t o, int lo, int hi);
        logic [9:0] w;
        for (int i = lo; i <= hi; i++)
        begin
            if (i == lo)
                w = 10'd0;
            else if (i == hi)
                w = 10'd1023;
            else
                w = load_word(o);
            send_load(o, 10'(i), w);
        end
    endtask

    task automatic run_random(int count);
        jcr_op_t o;
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
                brisk = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 85)
                send_pixel(random_coord(), random_coord(),
                           random_channel(), random_channel(), random_channel());
            else
            begin
                o = jcr_op_t'($urandom_range(1, 3));
                send_load(o, 10'($urandom_range(0, 1023)), load_word(o));
            end
        end
        brisk = 1'b0;
    endtask

    // Stops offering words and waits until every expected result is back.
    task automatic drain();
        int n;
        in_valid <= 1'b0;
        @(posedge clk);
        for (n = 0; n < 4000 && sb.pending() > 0; n++)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_noise(logic [NOISE_W-1:0] lvl);
        cfg_we    <= 1'b1;
        cfg_wdata <= lvl;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_noise(lvl);
    endtask

    // Result side: random stalls, and a long hold-off when one is requested.
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            if (hold_due)
            begin
                hold_due = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall = gap_draw();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        logic [NOISE_W-1:0] levels [4];
        levels = '{2'd0, 2'd3, 2'd1, 2'd2};
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every reachable entry is loaded before the first pixel goes in.
        fill_table(OP_LOAD_ORDER, ORD_FIRST, ORD_LAST);
        fill_table(OP_LOAD_X, JIT_FIRST, JIT_LAST);
        fill_table(OP_LOAD_Y, JIT_FIRST, JIT_LAST);

        send_pixel(14'd0, 14'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(14'd16383, 14'd16383, 8'd255, 8'd255, 8'd255);
        send_pixel(14'd16383, 14'd0, 8'd247, 8'd248, 8'd8);
        send_pixel(14'd0, 14'd16383, 8'd7, 8'd15, 8'd232);
        send_pixel(14'd1023, 14'd1024, 8'd1, 8'd2, 8'd3);
        send_pixel(14'h2bfe, 14'h1402, 8'd250, 8'd6, 8'd240);
        send_load(OP_LOAD_ORDER, 10'd0, 10'd1023);
        send_load(OP_LOAD_X, 10'd1023, 10'd1023);
        send_load(OP_LOAD_X, 10'd512, 10'd0);
        send_load(OP_LOAD_Y, 10'd1023, 10'd1023);
        send_load(OP_LOAD_Y, 10'd0, 10'd0);
        send_load(OP_LOAD_Y, 10'd511, 10'd512);
        send_pixel(14'd0, 14'd0, 8'd255, 8'd0, 8'd247);
        send_pixel(14'd1, 14'd1022, 8'd4, 8'd244, 8'd128);
        send_pixel(14'd4092, 14'd1, 8'd249, 8'd16, 8'd248);
        for (int i = 0; i < 6; i++)
            send_pixel(random_coord(), random_coord(),
                       8'(i), 8'(247 - i), 8'(i * 8));

        run_random(PHASE_WORDS);

        // Each noise level gets a freshly loaded Y window before its phase.
        for (int k = 0; k < 4; k++)
        begin
            drain();
            set_noise(levels[k]);
            fill_table(OP_LOAD_Y, JIT_FIRST, JIT_LAST);
            if (k == 1 || k == 3)
                hold_due = 1'b1;
            run_random(PHASE_WORDS);
        end

        drain();
        sb.errors += sb.pending();
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
